// ===== rtl/core/indenter_contact_force_accumulator_macros.svh =====
// assertion macros for the indenter contact force accumulator
`ifndef INDENTER_CONTACT_FORCE_ACCUMULATOR_MACROS_SVH
`define INDENTER_CONTACT_FORCE_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ICFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icfa check failed");
// next-cycle implication
`define ICFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icfa check failed");
`else
`define ICFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ICFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/icfa_pkg.sv =====
// types, constants and helper functions of the indenter contact force accumulator
`default_nettype none
package icfa_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int SUM_WIDTH   = 48;
    localparam int REG_WIDTH   = 31;
    localparam int CFG_WIDTH   = 32;
    localparam int IDX_WIDTH   = 8;
    localparam int OPA_WIDTH   = 64;
    localparam int OPB_WIDTH   = 32;
    localparam int PROD_WIDTH  = OPA_WIDTH + OPB_WIDTH;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] CFG_RADIUS  = 8'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_STIFF   = 8'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_CTR_X   = 8'd2;
    localparam logic [IDX_WIDTH-1:0] CFG_CTR_Y   = 8'd3;
    localparam logic [IDX_WIDTH-1:0] CFG_CTR_Z   = 8'd4;
    localparam logic [IDX_WIDTH-1:0] CFG_SHIFT_X = 8'd5;
    localparam logic [IDX_WIDTH-1:0] CFG_SHIFT_Y = 8'd6;
    localparam logic [IDX_WIDTH-1:0] CFG_SHIFT_Z = 8'd7;

    localparam logic [OPA_WIDTH-1:0] CAP63   = {1'b0, {(OPA_WIDTH-1){1'b1}}};
    localparam logic [OPA_WIDTH-1:0] SUM_CAP =
        {{(OPA_WIDTH-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] ACC_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] ACC_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] node_x;
        logic signed [COORD_WIDTH-1:0] node_y;
        logic signed [COORD_WIDTH-1:0] node_z;
        logic        [31:0]            node_weight;
        logic                          last_node;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] accel_dx;
        logic signed [COORD_WIDTH-1:0] accel_dy;
        logic signed [COORD_WIDTH-1:0] accel_dz;
        logic                          in_contact;
        logic signed [SUM_WIDTH-1:0]   total_force_x;
        logic signed [SUM_WIDTH-1:0]   total_force_y;
        logic signed [SUM_WIDTH-1:0]   total_force_z;
        logic signed [SUM_WIDTH-1:0]   total_energy;
        logic                          pass_done;
    } t_out_item;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_OFFS   = 9'b000000010,
        S_MUL0   = 9'b000000100,
        S_MUL1   = 9'b000001000,
        S_POST   = 9'b000010000,
        S_SQRT   = 9'b000100000,
        S_DIVCHK = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    typedef enum logic [3:0] {
        STP_RR, STP_SQ0, STP_SQ1, STP_SQ2, STP_DR2, STP_DR3,
        STP_E, STP_G, STP_H, STP_ACC
    } t_step;

    // drop the fraction bits of a product and clamp at cap
    function automatic logic [OPA_WIDTH-1:0] shr_sat(input logic [PROD_WIDTH-1:0] p,
                                                     input logic [OPA_WIDTH-1:0] cap);
        logic [PROD_WIDTH-1:0] v;
        v = p >> FRAC_BITS;
        return (v > {{OPB_WIDTH{1'b0}}, cap}) ? cap : v[OPA_WIDTH-1:0];
    endfunction

    // saturating add into a running total
    function automatic logic [SUM_WIDTH-1:0] sum_sat_add(input logic [SUM_WIDTH-1:0] a,
                                                         input logic [SUM_WIDTH:0] b);
        logic signed [SUM_WIDTH+1:0] s;
        logic signed [SUM_WIDTH+1:0] smax;
        logic signed [SUM_WIDTH+1:0] smin;
        smax = {3'b000, {(SUM_WIDTH-1){1'b1}}};
        smin = ~smax;
        s = $signed({{2{a[SUM_WIDTH-1]}}, a}) + $signed({b[SUM_WIDTH], b});
        if (s > smax) return smax[SUM_WIDTH-1:0];
        if (s < smin) return smin[SUM_WIDTH-1:0];
        return s[SUM_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/indenter_contact_force_accumulator.sv =====
// indenter contact force accumulator: sequenced datapath around a shared multiplier
// outside the cube the result follows the box test, outside the sphere the sum of squares;
// in contact: 12 two-pass 64x32 multiplies, a 32-step square root and three 32-step divides,
// each divide cut short for a zero or saturated axis; idle comes before the next node is taken
// the next node is taken while the last result waits; a full output register holds the sequencer
// sync active-low reset clears config, control and totals (not payload); no clearing pass
`default_nettype none
`include "indenter_contact_force_accumulator_macros.svh"
module indenter_contact_force_accumulator
    import icfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data
);

    localparam int DW = COORD_WIDTH + 2;

    // configuration
    logic [REG_WIDTH-1:0]          r_radius, r_stiff;
    logic signed [COORD_WIDTH-1:0] r_ctr_x, r_ctr_y, r_ctr_z;
    logic signed [COORD_WIDTH-1:0] r_sh_x, r_sh_y, r_sh_z;

    // control
    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;

    // datapath
    t_in_item r_node, n_node;
    logic [DW-1:0]   r_mag [3];
    logic [DW-1:0]   n_mag [3];
    logic            r_neg [3];
    logic            n_neg [3];
    logic            r_contact, n_contact;
    logic [OPA_WIDTH-1:0]  r_a, n_a;
    logic [OPB_WIDTH-1:0]  r_b, n_b;
    logic [PROD_WIDTH-1:0] r_prod, n_prod;
    logic [OPA_WIDTH-1:0]  r_rr, n_rr, r_sq, n_sq, r_sres, n_sres, r_sbit, n_sbit;
    logic [31:0] r_root, n_root, r_dr, n_dr;
    logic [OPA_WIDTH-1:0] r_dr2, n_dr2, r_dr3, n_dr3, r_e, n_e, r_g, n_g, r_h, n_h;
    logic [31:0] r_rem, n_rem, r_lo, n_lo, r_q, n_q;
    logic [COORD_WIDTH-1:0] r_acc [3];
    logic [COORD_WIDTH-1:0] n_acc [3];
    logic [SUM_WIDTH-1:0] r_sfx, r_sfy, r_sfz, r_se, n_sfx, n_sfy, n_sfz, n_se;
    t_out_item r_out, n_out;

    // scratch
    logic signed [DW-1:0] d_x, d_y, d_z;
    logic [DW-1:0]        rad_ext;
    logic [63:0]          pp;
    logic [PROD_WIDTH-1:0] p3;
    logic [OPA_WIDTH-1:0] sqsum, strial;
    logic [32:0]          dtrial;
    logic                 qsat;
    logic [31:0]          qfin;
    logic [31:0]          mag_next;
    logic [SUM_WIDTH-1:0] t_fx, t_fy, t_fz, t_e;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_stiff  <= '0;
            r_ctr_x  <= '0;
            r_ctr_y  <= '0;
            r_ctr_z  <= '0;
            r_sh_x   <= '0;
            r_sh_y   <= '0;
            r_sh_z   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:  r_radius <= i_cfg_data[REG_WIDTH-1:0];
                CFG_STIFF:   r_stiff  <= i_cfg_data[REG_WIDTH-1:0];
                CFG_CTR_X:   r_ctr_x  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_CTR_Y:   r_ctr_y  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_CTR_Z:   r_ctr_z  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_SHIFT_X: r_sh_x   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_SHIFT_Y: r_sh_y   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_SHIFT_Z: r_sh_z   <= i_cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // offsets from the indenter centre plus shift
    assign d_x = DW'(r_node.node_x) - DW'(r_ctr_x) + DW'(r_sh_x);
    assign d_y = DW'(r_node.node_y) - DW'(r_ctr_y) + DW'(r_sh_y);
    assign d_z = DW'(r_node.node_z) - DW'(r_ctr_z) + DW'(r_sh_z);
    assign rad_ext = {{(DW-REG_WIDTH){1'b0}}, r_radius};

    // sequencer
    always_comb begin
        n_state = r_state;  n_step = r_step;  n_out_valid = r_out_valid;
        n_cnt = r_cnt;  n_axis = r_axis;  n_node = r_node;
        n_mag = r_mag;  n_neg = r_neg;  n_contact = r_contact;
        n_a = r_a;  n_b = r_b;  n_prod = r_prod;
        n_rr = r_rr;  n_sq = r_sq;  n_sres = r_sres;  n_sbit = r_sbit;
        n_root = r_root;  n_dr = r_dr;
        n_dr2 = r_dr2;  n_dr3 = r_dr3;  n_e = r_e;  n_g = r_g;  n_h = r_h;
        n_rem = r_rem;  n_lo = r_lo;  n_q = r_q;  n_acc = r_acc;
        n_sfx = r_sfx;  n_sfy = r_sfy;  n_sfz = r_sfz;  n_se = r_se;
        n_out = r_out;
        pp = '0;  p3 = '0;  sqsum = '0;  strial = '0;  dtrial = '0;
        qsat = 1'b0;  qfin = '0;  mag_next = '0;
        t_fx = r_sfx;  t_fy = r_sfy;  t_fz = r_sfz;  t_e = r_se;

        // output register drains independently
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_node  = i_in_data;
                    n_state = S_OFFS;
                end
            end
            // magnitudes and box test against the radius
            S_OFFS: begin
                n_neg[0] = d_x[DW-1];
                n_neg[1] = d_y[DW-1];
                n_neg[2] = d_z[DW-1];
                n_mag[0] = d_x[DW-1] ? DW'(-d_x) : DW'(d_x);
                n_mag[1] = d_y[DW-1] ? DW'(-d_y) : DW'(d_y);
                n_mag[2] = d_z[DW-1] ? DW'(-d_z) : DW'(d_z);
                n_acc[0] = '0;
                n_acc[1] = '0;
                n_acc[2] = '0;
                n_contact = (n_mag[0] < rad_ext) && (n_mag[1] < rad_ext)
                            && (n_mag[2] < rad_ext);
                if (n_contact) begin
                    n_a     = OPA_WIDTH'(r_radius);
                    n_b     = OPB_WIDTH'(r_radius);
                    n_step  = STP_RR;
                    n_state = S_MUL0;
                end else begin
                    n_state = S_FIN;
                end
            end
            // shared multiplier, low then high half of operand a
            S_MUL0: begin
                pp      = r_a[31:0] * r_b;
                n_prod  = {{OPB_WIDTH{1'b0}}, pp};
                n_state = S_MUL1;
            end
            S_MUL1: begin
                pp      = r_a[63:32] * r_b;
                n_prod  = r_prod + {pp, 32'b0};
                n_state = S_POST;
            end
            // consume the product and set up the next step
            S_POST: begin
                n_state = S_MUL0;
                case (r_step)
                    STP_RR: begin
                        n_rr   = r_prod[OPA_WIDTH-1:0];
                        n_a    = OPA_WIDTH'(r_mag[0][31:0]);
                        n_b    = r_mag[0][31:0];
                        n_step = STP_SQ0;
                    end
                    STP_SQ0: begin
                        n_sq   = r_prod[OPA_WIDTH-1:0];
                        n_a    = OPA_WIDTH'(r_mag[1][31:0]);
                        n_b    = r_mag[1][31:0];
                        n_step = STP_SQ1;
                    end
                    STP_SQ1: begin
                        n_sq   = r_sq + r_prod[OPA_WIDTH-1:0];
                        n_a    = OPA_WIDTH'(r_mag[2][31:0]);
                        n_b    = r_mag[2][31:0];
                        n_step = STP_SQ2;
                    end
                    STP_SQ2: begin
                        sqsum = r_sq + r_prod[OPA_WIDTH-1:0];
                        n_sq  = sqsum;
                        if (sqsum >= r_rr) begin
                            n_contact = 1'b0;
                            n_state   = S_FIN;
                        end else begin
                            n_sres  = '0;
                            n_sbit  = {2'b01, {(OPA_WIDTH-2){1'b0}}};
                            n_cnt   = 5'd31;
                            n_state = S_SQRT;
                        end
                    end
                    STP_DR2: begin
                        n_dr2  = shr_sat(r_prod, CAP63);
                        n_a    = n_dr2;
                        n_b    = r_dr;
                        n_step = STP_DR3;
                    end
                    STP_DR3: begin
                        n_dr3  = shr_sat(r_prod, CAP63);
                        n_a    = n_dr3;
                        n_b    = OPB_WIDTH'(r_stiff);
                        n_step = STP_E;
                    end
                    STP_E: begin
                        n_e    = shr_sat(r_prod, SUM_CAP);
                        n_a    = r_dr2;
                        n_b    = OPB_WIDTH'(r_stiff);
                        n_step = STP_G;
                    end
                    STP_G: begin
                        p3     = r_prod + {r_prod[PROD_WIDTH-2:0], 1'b0};
                        n_g    = shr_sat(p3, CAP63);
                        n_a    = n_g;
                        n_b    = r_node.node_weight;
                        n_step = STP_H;
                    end
                    STP_H: begin
                        n_h    = shr_sat(r_prod, CAP63);
                        n_a    = n_h;
                        n_b    = r_mag[0][31:0];
                        n_axis = 2'd0;
                        n_step = STP_ACC;
                    end
                    STP_ACC: begin
                        n_state = S_DIVCHK;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            // integer square root, two bits of the radicand per cycle
            S_SQRT: begin
                strial = r_sres + r_sbit;
                if (r_sq >= strial) begin
                    n_sq   = r_sq - strial;
                    n_sres = (r_sres >> 1) + r_sbit;
                end else begin
                    n_sres = r_sres >> 1;
                end
                n_sbit = r_sbit >> 2;
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_root  = n_sres[31:0];
                    n_dr    = 32'(r_radius) - n_sres[31:0];
                    n_a     = OPA_WIDTH'(n_dr);
                    n_b     = n_dr;
                    n_step  = STP_DR2;
                    n_state = S_MUL0;
                end
            end
            // quotient overflow check, zero component skip
            S_DIVCHK: begin
                if (r_mag[r_axis] == '0) begin
                    n_acc[r_axis] = '0;
                    n_state       = S_DIV;
                    n_cnt         = 5'd0;
                    n_q           = '0;
                    n_rem         = '0;
                    n_lo          = '0;
                end else if (r_prod[PROD_WIDTH-1:32] >= {32'b0, r_root}) begin
                    n_acc[r_axis] = r_neg[r_axis] ? ACC_MIN : ACC_MAX;
                    n_cnt         = 5'd0;
                    n_q           = '0;
                    n_rem         = '0;
                    n_lo          = '0;
                    n_state       = S_DIV;
                end else begin
                    n_rem   = r_prod[63:32];
                    n_lo    = r_prod[31:0];
                    n_q     = '0;
                    n_cnt   = 5'd31;
                    n_state = S_DIV;
                end
            end
            // restoring divide by the root, one quotient bit per cycle
            S_DIV: begin
                dtrial = {r_rem, r_lo[31]};
                if (dtrial >= {1'b0, r_root}) begin
                    n_rem = 32'(dtrial - {1'b0, r_root});
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_rem = dtrial[31:0];
                    n_q   = {r_q[30:0], 1'b0};
                end
                n_lo  = {r_lo[30:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    // a skipped or saturated axis arrives here with a cleared count
                    if (r_mag[r_axis] != '0
                        && r_prod[PROD_WIDTH-1:32] < {32'b0, r_root}) begin
                        qfin = n_q;
                        qsat = qfin[31];
                        if (r_neg[r_axis]) n_acc[r_axis] = qsat ? ACC_MIN : 32'(-qfin);
                        else               n_acc[r_axis] = qsat ? ACC_MAX : qfin;
                    end
                    if (r_axis == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        mag_next = (r_axis == 2'd0) ? r_mag[1][31:0] : r_mag[2][31:0];
                        n_axis   = r_axis + 2'd1;
                        n_a      = r_h;
                        n_b      = mag_next;
                        n_step   = STP_ACC;
                        n_state  = S_MUL0;
                    end
                end
            end
            // totals update and result transfer into the output register
            S_FIN: begin
                if (r_contact) begin
                    t_fx = sum_sat_add(r_sfx,
                        -{{(SUM_WIDTH+1-COORD_WIDTH){r_acc[0][COORD_WIDTH-1]}}, r_acc[0]});
                    t_fy = sum_sat_add(r_sfy,
                        -{{(SUM_WIDTH+1-COORD_WIDTH){r_acc[1][COORD_WIDTH-1]}}, r_acc[1]});
                    t_fz = sum_sat_add(r_sfz,
                        -{{(SUM_WIDTH+1-COORD_WIDTH){r_acc[2][COORD_WIDTH-1]}}, r_acc[2]});
                    t_e  = sum_sat_add(r_se, {1'b0, r_e[SUM_WIDTH-1:0]});
                end
                if (!r_out_valid || !i_out_stall) begin
                    n_out.accel_dx      = r_contact ? r_acc[0] : '0;
                    n_out.accel_dy      = r_contact ? r_acc[1] : '0;
                    n_out.accel_dz      = r_contact ? r_acc[2] : '0;
                    n_out.in_contact    = r_contact;
                    n_out.total_force_x = t_fx;
                    n_out.total_force_y = t_fy;
                    n_out.total_force_z = t_fz;
                    n_out.total_energy  = t_e;
                    n_out.pass_done     = r_node.last_node;
                    n_out_valid         = 1'b1;
                    n_sfx = r_node.last_node ? '0 : t_fx;
                    n_sfy = r_node.last_node ? '0 : t_fy;
                    n_sfz = r_node.last_node ? '0 : t_fz;
                    n_se  = r_node.last_node ? '0 : t_e;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STP_RR;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_contact   <= 1'b0;
            r_sfx       <= '0;
            r_sfy       <= '0;
            r_sfz       <= '0;
            r_se        <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_contact   <= n_contact;
            r_sfx       <= n_sfx;
            r_sfy       <= n_sfy;
            r_sfz       <= n_sfz;
            r_se        <= n_se;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= n_prod;
        r_rr   <= n_rr;
        r_sq   <= n_sq;
        r_sres <= n_sres;
        r_sbit <= n_sbit;
        r_root <= n_root;
        r_dr   <= n_dr;
        r_dr2  <= n_dr2;
        r_dr3  <= n_dr3;
        r_e    <= n_e;
        r_g    <= n_g;
        r_h    <= n_h;
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_q    <= n_q;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    // checks
    `ICFA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_state == S_OFFS)
    `ICFA_ASSERT_NOW(a_no_contact_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.in_contact,
        r_out.accel_dx == '0 && r_out.accel_dy == '0 && r_out.accel_dz == '0)
    `ICFA_ASSERT_NEXT(a_pass_clears, i_clk, i_rst_n,
        r_state == S_FIN && r_node.last_node && (!r_out_valid || !i_out_stall),
        r_sfx == '0 && r_sfy == '0 && r_sfz == '0 && r_se == '0)
    `ICFA_ASSERT_NOW(a_rem_below_root, i_clk, i_rst_n,
        r_state == S_DIV && r_cnt != 5'd0, r_rem < r_root)

endmodule
`default_nettype wire
